// ----- hw/rtl/dar_pkg.sv -----
// Package for the DNS A-record responder: sizes, register indexes,
// the front-to-back command type and header byte lookup.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dar_pkg;

    localparam int MAX_DATAGRAM = 512;
    localparam int HDR_LEN      = 12;
    localparam int ANS_LEN      = 16;
    localparam int COPY_LIMIT   = MAX_DATAGRAM - ANS_LEN;
    localparam int POS_W        = $clog2(MAX_DATAGRAM + 1);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ANSWER_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANSWER_TTL     = 1'd1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // One command: header bytes [hdr_lo, hdr_hi), then an optional copied
    // query byte, then optionally the 16-byte answer record.
    typedef struct packed {
        logic [15:0] id;
        logic [3:0]  hdr_lo;
        logic [3:0]  hdr_hi;
        logic        has_copy;
        logic [7:0]  copy_byte;
        logic        answer;
    } cmd_t;

    function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] id);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = id[15:8];
            4'd1:    b = id[7:0];
            4'd2:    b = 8'h84;
            4'd5:    b = 8'h01;
            4'd7:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/dar_front.sv -----
// Front part: tracks the datagram position, captures the ID and turns
// each input byte into at most one command. Depends on dar_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dar_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    output dar_pkg::cmd_t      cmd,
    output logic               cmd_valid
);

    logic [dar_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [15:0]               id_reg, id_next;
    logic                      ignored_reg, ignored_next;

    always_comb
    begin
        pos_next     = pos_reg;
        id_next      = id_reg;
        ignored_next = ignored_reg;
        cmd_valid    = 1'b0;
        cmd.id        = id_reg;
        cmd.hdr_lo    = 4'd0;
        cmd.hdr_hi    = 4'd0;
        cmd.has_copy  = 1'b0;
        cmd.copy_byte = in_byte;
        cmd.answer    = 1'b0;

        if (pos_reg == '0) begin
            id_next[15:8] = in_byte;
        end else if (pos_reg == dar_pkg::POS_W'(1)) begin
            id_next[7:0] = in_byte;
        end else if (!ignored_reg) begin
            if (pos_reg == dar_pkg::POS_W'(2) && in_byte[7]) begin
                ignored_next = 1'b1;
            end else if (pos_reg < dar_pkg::POS_W'(dar_pkg::HDR_LEN)) begin
                cmd_valid  = 1'b1;
                cmd.hdr_lo = (pos_reg == dar_pkg::POS_W'(2)) ? 4'd0 : pos_reg[3:0];
                cmd.hdr_hi = in_last ? 4'(dar_pkg::HDR_LEN) : pos_reg[3:0] + 4'd1;
                cmd.answer = in_last;
            end else if (pos_reg < dar_pkg::POS_W'(dar_pkg::COPY_LIMIT)) begin
                cmd_valid    = 1'b1;
                cmd.has_copy = 1'b1;
                cmd.answer   = in_last;
            end else if (in_last) begin
                cmd_valid  = 1'b1;
                cmd.answer = 1'b1;
            end
        end

        if (in_last) begin
            pos_next     = '0;
            ignored_next = 1'b0;
        end else if (pos_reg < dar_pkg::POS_W'(dar_pkg::MAX_DATAGRAM)) begin
            pos_next = pos_reg + dar_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg     <= '0;
            id_reg      <= '0;
            ignored_reg <= 1'b0;
        end else if (accept) begin
            pos_reg     <= pos_next;
            id_reg      <= id_next;
            ignored_reg <= ignored_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/dar_cmd_fifo.sv -----
// Small command queue between front and back.
// Depends on dar_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dar_cmd_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire dar_pkg::cmd_t wr_cmd,
    output logic               full,
    input  wire logic          rd_en,
    output dar_pkg::cmd_t      rd_cmd,
    output logic               rd_valid
);

    dar_pkg::cmd_t               mem_reg [dar_pkg::FIFO_DEPTH];
    logic [dar_pkg::FIFO_AW-1:0] wptr_reg, rptr_reg;
    logic [dar_pkg::FIFO_AW:0]   cnt_reg, cnt_next;

    assign full     = (cnt_reg == (dar_pkg::FIFO_AW+1)'(dar_pkg::FIFO_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_cmd   = mem_reg[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !(rd_en && rd_valid))
            cnt_next = cnt_reg + (dar_pkg::FIFO_AW+1)'(1);
        else if (!wr_en && rd_en && rd_valid)
            cnt_next = cnt_reg - (dar_pkg::FIFO_AW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (wr_en)
                wptr_reg <= wptr_reg + dar_pkg::FIFO_AW'(1);
            if (rd_en && rd_valid)
                rptr_reg <= rptr_reg + dar_pkg::FIFO_AW'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/dar_back.sv -----
// Back part: expands each queued command into response bytes, one per
// cycle unless pop holds the output, into the output register. Depends on dar_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dar_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire dar_pkg::cmd_t cmd,
    input  wire logic          cmd_valid,
    output logic               cmd_pop,
    input  wire logic [31:0]   answer_address,
    input  wire logic [31:0]   answer_ttl,
    output logic               empty,
    input  wire logic          pop,
    output logic [7:0]         out_byte,
    output logic               out_last
);

    typedef enum logic [1:0] {PH_HDR, PH_COPY, PH_ANS} phase_t;

    phase_t     phase_reg, phase_next, eph;
    logic [3:0] idx_reg, idx_next, eidx;
    logic       fresh_reg, fresh_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg, byte_now;
    logic       out_last_reg, last_now;
    logic       adv, done;

    assign adv      = cmd_valid && (!out_valid_reg || pop);
    assign empty    = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign out_last = out_last_reg;
    assign cmd_pop  = adv && done;

    always_comb
    begin
        if (fresh_reg) begin
            if (cmd.hdr_lo < cmd.hdr_hi)
                eph = PH_HDR;
            else if (cmd.has_copy)
                eph = PH_COPY;
            else
                eph = PH_ANS;
            eidx = (cmd.hdr_lo < cmd.hdr_hi) ? cmd.hdr_lo : 4'd0;
        end else begin
            eph  = phase_reg;
            eidx = idx_reg;
        end

        last_now = 1'b0;
        unique case (eidx)
            4'd0:    byte_now = 8'hC0;
            4'd1:    byte_now = 8'h0C;
            4'd3:    byte_now = 8'h01;
            4'd5:    byte_now = 8'h01;
            4'd6:    byte_now = answer_ttl[31:24];
            4'd7:    byte_now = answer_ttl[23:16];
            4'd8:    byte_now = answer_ttl[15:8];
            4'd9:    byte_now = answer_ttl[7:0];
            4'd11:   byte_now = 8'h04;
            4'd12:   byte_now = answer_address[31:24];
            4'd13:   byte_now = answer_address[23:16];
            4'd14:   byte_now = answer_address[15:8];
            4'd15:   byte_now = answer_address[7:0];
            default: byte_now = 8'h00;
        endcase

        done       = 1'b0;
        phase_next = eph;
        idx_next   = eidx;
        fresh_next = 1'b0;
        unique case (eph)
            PH_HDR:
            begin
                byte_now = dar_pkg::hdr_byte(eidx, cmd.id);
                if (eidx + 4'd1 < cmd.hdr_hi) begin
                    idx_next = eidx + 4'd1;
                end else if (cmd.has_copy) begin
                    phase_next = PH_COPY;
                end else if (cmd.answer) begin
                    phase_next = PH_ANS;
                    idx_next   = 4'd0;
                end else begin
                    done = 1'b1;
                end
            end
            PH_COPY:
            begin
                byte_now = cmd.copy_byte;
                if (cmd.answer) begin
                    phase_next = PH_ANS;
                    idx_next   = 4'd0;
                end else begin
                    done = 1'b1;
                end
            end
            PH_ANS:
            begin
                if (eidx == 4'(dar_pkg::ANS_LEN - 1)) begin
                    last_now = 1'b1;
                    done     = 1'b1;
                end else begin
                    idx_next = eidx + 4'd1;
                end
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
        if (done)
            fresh_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_HDR;
            idx_reg       <= 4'd0;
            fresh_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                phase_reg     <= phase_next;
                idx_reg       <= idx_next;
                fresh_reg     <= fresh_next;
                out_valid_reg <= 1'b1;
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            out_byte_reg <= byte_now;
            out_last_reg <= last_now;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/dns_a_record_responder.sv -----
// Top level of the DNS A-record responder: configuration registers and
// the front / command queue / back chain. Depends on dar_pkg, dar_front,
// dar_cmd_fifo and dar_back.
//
// Usage:
//   Input channel: query bytes with in_last on the final byte; a transaction
//   completes when push is high and full is low. One byte per cycle is taken.
//   Output channel: response bytes with out_last on the final byte; the
//   oldest byte is shown while empty is low and leaves when pop is high.
//   Config channel: cfg_valid/cfg_ready with cfg_index (0 = answer_address,
//   1 = answer_ttl) and cfg_data; cfg_ready is always high.
//   Path: each command passes through the command queue and the output
//   register before its first response byte is shown. The back emits one
//   byte per cycle while pop keeps up, so query bytes stream through at full
//   rate; input byte 2 expands to three bytes and the last byte to up to 28.
//   While the back works through them the 4-entry command queue keeps taking
//   transactions; full rises once it holds four commands.
//   Stall: when pop stays low the output register holds, the queue fills
//   and full goes high; nothing is dropped.
//   Reset: position, ID and ignore flag clear, the queue and output empty,
//   and the registers return to 0xC0A80307 / 10.
`timescale 1ns / 1ps
`default_nettype none
module dns_a_record_responder (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [7:0]                     in_byte,
    input  wire logic                           in_last,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [7:0]                          out_byte,
    output logic                                out_last,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [dar_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                    cfg_data
);

    logic [31:0]   answer_address_reg;
    logic [31:0]   answer_ttl_reg;
    logic          accept;
    dar_pkg::cmd_t front_cmd, head_cmd;
    logic          front_valid, head_valid, head_pop;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            answer_address_reg <= 32'hC0A80307;
            answer_ttl_reg     <= 32'd10;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                dar_pkg::REG_ANSWER_ADDRESS: answer_address_reg <= cfg_data;
                dar_pkg::REG_ANSWER_TTL:     answer_ttl_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Classifies each byte; at most one command per transaction.
    dar_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .cmd       (front_cmd),
        .cmd_valid (front_valid)
    );

    dar_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && front_valid),
        .wr_cmd   (front_cmd),
        .full     (full),
        .rd_en    (head_pop),
        .rd_cmd   (head_cmd),
        .rd_valid (head_valid)
    );

    dar_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (head_cmd),
        .cmd_valid      (head_valid),
        .cmd_pop        (head_pop),
        .answer_address (answer_address_reg),
        .answer_ttl     (answer_ttl_reg),
        .empty          (empty),
        .pop            (pop),
        .out_byte       (out_byte),
        .out_last       (out_last)
    );

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for the DNS A-record responder: streams query datagrams
// in, predicts every response byte and compares the two streams.
// Depends on dar_pkg and dns_a_record_responder.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

    // DNS constants the predicted response is built from
    localparam logic [7:0] FLAGS_QR_AA   = 8'h84;   // response, authoritative
    localparam logic [7:0] COUNT_ONE     = 8'h01;   // low byte of QDCOUNT/ANCOUNT
    localparam logic [7:0] NAME_PTR_HI   = 8'hC0;   // compression pointer to
    localparam logic [7:0] NAME_PTR_LO   = 8'h0C;   // the question name
    localparam logic [7:0] RR_TYPE_A     = 8'h01;
    localparam logic [7:0] RR_CLASS_IN   = 8'h01;
    localparam logic [7:0] RDLEN_IPV4    = 8'h04;
    localparam int         QR_BIT        = 7;
    localparam logic [31:0] RESET_ADDRESS = 32'hC0A8_0307;
    localparam logic [31:0] RESET_TTL     = 32'd10;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int ITEMS_PER_STEP = 50;   // random bytes per idling regime
    localparam int FILL_RANDOM    = -1;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } reply_byte_t;

    // Scoreboard: mirrors the responder state and holds the reply bytes
    // still owed by the block, oldest first.
    class dns_reply_tracker;
        reply_byte_t               pending_reply[$];
        logic [31:0]               answer_address;
        logic [31:0]               answer_ttl;
        logic [dar_pkg::POS_W-1:0] position;
        logic [15:0]               query_id;
        logic                      ignoring;
        int                        error_count;

        function new();
            answer_address = RESET_ADDRESS;
            answer_ttl     = RESET_TTL;
            position       = '0;
            query_id       = '0;
            ignoring       = 1'b0;
            error_count    = 0;
        endfunction

        function void note_register(logic [dar_pkg::CFG_IDX_W-1:0] idx,
                                    logic [31:0] value);
            if (idx == dar_pkg::REG_ANSWER_ADDRESS)
                answer_address = value;
            else if (idx == dar_pkg::REG_ANSWER_TTL)
                answer_ttl = value;
        endfunction

        function logic [7:0] header_byte(int idx);
            case (idx)
                0:       return query_id[15:8];
                1:       return query_id[7:0];
                2:       return FLAGS_QR_AA;
                5:       return COUNT_ONE;
                7:       return COUNT_ONE;
                default: return 8'h00;
            endcase
        endfunction

        function void owe(logic [7:0] data, logic last);
            reply_byte_t r;
            r.data = data;
            r.last = last;
            pending_reply.push_back(r);
        endfunction

        // Works out the reply bytes caused by one accepted query byte.
        function void note_query_byte(logic [7:0] b, logic last);
            int         p;
            int         i;
            logic [7:0] rr[16];
            p = position;
            if (p == 0)
                query_id[15:8] = b;
            else if (p == 1)
                query_id[7:0] = b;
            else if (!ignoring) begin
                if (p == 2 && b[QR_BIT])
                    ignoring = 1'b1;
                else if (p == 2) begin
                    for (i = 0; i < 3; i++)
                        owe(header_byte(i), 1'b0);
                end
                else if (p < dar_pkg::HDR_LEN)
                    owe(header_byte(p), 1'b0);
                else if (p < dar_pkg::COPY_LIMIT)
                    owe(b, 1'b0);
            end
            if (last) begin
                if (p >= 2 && !ignoring) begin
                    // finish a truncated header, then the answer record
                    for (i = p + 1; i < dar_pkg::HDR_LEN; i++)
                        owe(header_byte(i), 1'b0);
                    rr[0]  = NAME_PTR_HI;  rr[1]  = NAME_PTR_LO;
                    rr[2]  = 8'h00;        rr[3]  = RR_TYPE_A;
                    rr[4]  = 8'h00;        rr[5]  = RR_CLASS_IN;
                    rr[6]  = answer_ttl[31:24];
                    rr[7]  = answer_ttl[23:16];
                    rr[8]  = answer_ttl[15:8];
                    rr[9]  = answer_ttl[7:0];
                    rr[10] = 8'h00;        rr[11] = RDLEN_IPV4;
                    rr[12] = answer_address[31:24];
                    rr[13] = answer_address[23:16];
                    rr[14] = answer_address[15:8];
                    rr[15] = answer_address[7:0];
                    for (i = 0; i < dar_pkg::ANS_LEN; i++)
                        owe(rr[i], i == dar_pkg::ANS_LEN - 1);
                end
                position = '0;
                ignoring = 1'b0;
            end
            else if (p < dar_pkg::MAX_DATAGRAM)
                position = dar_pkg::POS_W'(p + 1);
        endfunction

        function void check_reply_byte(logic [7:0] data, logic last);
            reply_byte_t want;
            if (pending_reply.size() == 0) begin
                $error("unexpected reply byte %h (last %b)", data, last);
                error_count++;
                return;
            end
            want = pending_reply.pop_front();
            if (data !== want.data) begin
                $error("out_byte mismatch: expected %h, actual %h", want.data, data);
                error_count++;
            end
            if (last !== want.last) begin
                $error("out_last mismatch: expected %b, actual %b", want.last, last);
                error_count++;
            end
        endfunction
    endclass

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          push      = 1'b0;
    logic                          full;
    logic [7:0]                    in_byte   = 8'h00;
    logic                          in_last   = 1'b0;
    logic                          empty;
    logic                          pop       = 1'b0;
    logic [7:0]                    out_byte;
    logic                          out_last;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [dar_pkg::CFG_IDX_W-1:0] cfg_index = dar_pkg::REG_ANSWER_ADDRESS;
    logic [31:0]                   cfg_data  = '0;

    int send_gap_pct = 16;   // chance per cycle that the query side pauses
    int take_gap_pct = 49;   // chance per cycle that the reply side stalls
    int cycle_count  = 0;

    dns_reply_tracker tracker = new();

    dns_a_record_responder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake or a missing reply byte ends up here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Reply side: check the byte taken at this edge, then decide whether to
    // pop at the next one. pop gets exactly one assignment per edge.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            tracker.check_reply_byte(out_byte, out_last);
        pop <= rst_n && ($urandom_range(99) >= take_gap_pct);
    end

    // One query byte transaction. push stays high on return so back-to-back
    // bytes never lower and raise it in the same step.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_gap_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_byte <= b;
        in_last <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        tracker.note_query_byte(b, last);
    endtask

    // fill < 0 gives random bytes, else every byte is fill; bit 7 of byte 2
    // (QR) is forced to qr.
    task automatic send_packet(input int len, input int fill, input logic qr);
        logic [7:0] b;
        for (int k = 0; k < len; k++)
        begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            if (k == 2)
                b[QR_BIT] = qr;
            send_byte(b, k == len - 1);
        end
    endtask

    // Let every owed byte come out, then give the block time to finish any
    // datagram that produces nothing, so the registers can be rewritten.
    task automatic settle();
        push <= 1'b0;
        while (tracker.pending_reply.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_answer(input logic [31:0] address, input logic [31:0] ttl);
        for (int r = 0; r < 2; r++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= (r == 0) ? dar_pkg::REG_ANSWER_ADDRESS : dar_pkg::REG_ANSWER_TTL;
            cfg_data  <= (r == 0) ? address : ttl;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            tracker.note_register((r == 0) ? dar_pkg::REG_ANSWER_ADDRESS
                                           : dar_pkg::REG_ANSWER_TTL,
                                  (r == 0) ? address : ttl);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random datagrams: mostly well-formed queries so the copy path and the
    // answer get exercised, plus truncated headers, responses and runts.
    task automatic random_traffic(input int budget);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                len = $urandom_range(13, 40);
                send_packet(len, FILL_RANDOM, 1'b0);
            end
            else if (pick < 78)
            begin
                len = $urandom_range(3, 12);   // ends inside the header
                send_packet(len, FILL_RANDOM, 1'b0);
            end
            else if (pick < 88)
            begin
                len = $urandom_range(3, 30);   // already a response: no reply
                send_packet(len, FILL_RANDOM, 1'b1);
            end
            else if (pick < 94)
            begin
                len = $urandom_range(1, 2);    // too short to carry QR
                send_packet(len, FILL_RANDOM, 1'b0);
            end
            else
            begin
                len = $urandom_range(1, 40);
                send_packet(len, FILL_RANDOM, 1'($urandom_range(1)));
            end
            sent += len;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed datagrams at the reset answer settings.
        send_packet(1, FILL_RANDOM, 1'b0);   // ends on the first ID byte
        send_packet(2, 8'hFF, 1'b0);         // ends on the second ID byte
        send_packet(3, 8'hFF, 1'b1);         // response datagram, all ones
        send_packet(3, 8'h00, 1'b0);         // ends at the flags byte, zero ID
        send_packet(7, FILL_RANDOM, 1'b0);   // ends in the middle of the header
        send_packet(13, 8'hFF, 1'b0);        // one question byte copied, ID FFFF
        settle();

        for (int step = 0; step < 3; step++)
        begin
            case (step)
                0:
                begin
                    send_gap_pct = 16;
                    take_gap_pct = 49;
                    program_answer(32'h0000_0000, 32'h0000_0000);
                end
                1:
                begin
                    send_gap_pct = 49;
                    take_gap_pct = 16;
                    program_answer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                end
                default:
                begin
                    send_gap_pct = 0;
                    take_gap_pct = 0;
                    program_answer($urandom, $urandom);
                end
            endcase
            random_traffic(ITEMS_PER_STEP);
            settle();
        end

        if (tracker.error_count == 0 && tracker.pending_reply.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
